// ----- src/trifc_pkg.sv -----
// Shared types and constants for the trigram frequency counter.
`timescale 1ns / 1ps

package trifc_pkg;

  // Command codes on the input channel.
  localparam logic CMD_FEED  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Character codes recognized in the text stream.
  localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z  = 8'h7A;
  localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z  = 8'h5A;
  localparam logic [7:0] CHAR_SPACE    = 8'h20;
  localparam logic [7:0] CHAR_COMMA    = 8'h2C;
  localparam logic [7:0] CHAR_PERIOD   = 8'h2E;
  localparam logic [7:0] CHAR_EXCLAIM  = 8'h21;
  localparam logic [7:0] CHAR_QUESTION = 8'h3F;

  // Symbol codes of the punctuation part of the alphabet.
  localparam logic [4:0] SYM_SPACE    = 5'd26;
  localparam logic [4:0] SYM_COMMA    = 5'd27;
  localparam logic [4:0] SYM_PERIOD   = 5'd28;
  localparam logic [4:0] SYM_EXCLAIM  = 5'd29;
  localparam logic [4:0] SYM_QUESTION = 5'd30;

  // Index widths and depths of the counter memories, and the output count width.
  localparam int SYM_W        = 5;
  localparam int PAIR_IDX_W   = 2 * SYM_W;
  localparam int TRIPLE_IDX_W = 3 * SYM_W;
  localparam int PAIR_DEPTH   = 1 << PAIR_IDX_W;
  localparam int TRIPLE_DEPTH = 1 << TRIPLE_IDX_W;
  localparam int OUT_W        = 32;

  // Operation kinds passed from the front end to the back end.
  typedef enum logic {
    OP_COUNT,
    OP_QUERY
  } trifc_op_e;

  // One classified operation in the queue.
  typedef struct packed {
    trifc_op_e                 kind;
    logic [TRIPLE_IDX_W-1:0]   triple_idx;
    logic                      triple_ok;
    logic                      pair_ok;
  } trifc_op_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EXEC
  } trifc_bk_state_e;

  // Status from the back end to the top level.
  typedef struct packed {
    logic clearing;
    logic result_load;
  } trifc_status_t;

endpackage

// ----- src/trifc_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module trifc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- src/trifc_fifo.sv -----
// Small register queue between the front end and the back end.
`timescale 1ns / 1ps

module trifc_fifo #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- src/trifc_front.sv -----
// Front end: maps text bytes to symbols, keeps the history, classifies operations.
`timescale 1ns / 1ps

module trifc_front import trifc_pkg::*; #(
  parameter int ALPHABET_SIZE = 31
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic       command_i,
  input  logic [7:0] char_byte_i,
  input  logic [4:0] query_first_i,
  input  logic [4:0] query_second_i,
  input  logic [4:0] query_third_i,
  output logic       op_valid_o,
  output trifc_op_t  op_o
);

  localparam logic [SYM_W:0] ALPHA_LIMIT = (SYM_W + 1)'(ALPHABET_SIZE);

  logic [SYM_W-1:0] older_q, older_d;
  logic [SYM_W-1:0] newer_q, newer_d;
  logic [1:0]       fill_q, fill_d;
  logic             sym_valid;
  logic [SYM_W-1:0] sym;
  logic             is_feed;
  logic             history_full;
  logic             first_ok;
  logic             second_ok;
  logic             third_ok;

  // Byte to symbol mapping.
  always_comb begin
    sym_valid = 1'b1;
    sym       = '0;
    if (char_byte_i >= CHAR_LOWER_A && char_byte_i <= CHAR_LOWER_Z) begin
      sym = SYM_W'(char_byte_i - CHAR_LOWER_A);
    end else if (char_byte_i >= CHAR_UPPER_A && char_byte_i <= CHAR_UPPER_Z) begin
      sym = SYM_W'(char_byte_i - CHAR_UPPER_A);
    end else if (char_byte_i == CHAR_SPACE) begin
      sym = SYM_SPACE;
    end else if (char_byte_i == CHAR_COMMA) begin
      sym = SYM_COMMA;
    end else if (char_byte_i == CHAR_PERIOD) begin
      sym = SYM_PERIOD;
    end else if (char_byte_i == CHAR_EXCLAIM) begin
      sym = SYM_EXCLAIM;
    end else if (char_byte_i == CHAR_QUESTION) begin
      sym = SYM_QUESTION;
    end else begin
      sym_valid = 1'b0;
    end
  end

  assign is_feed      = (command_i == CMD_FEED);
  assign history_full = (fill_q == 2'd2);

  // Query codes outside the alphabet read as zero counts.
  assign first_ok  = ({1'b0, query_first_i} < ALPHA_LIMIT);
  assign second_ok = ({1'b0, query_second_i} < ALPHA_LIMIT);
  assign third_ok  = ({1'b0, query_third_i} < ALPHA_LIMIT);

  // Classification of the accepted transaction.
  always_comb begin
    op_valid_o = 1'b0;
    op_o       = '0;
    if (is_feed) begin
      op_valid_o      = accept_i && sym_valid && history_full;
      op_o.kind       = OP_COUNT;
      op_o.triple_idx = {older_q, newer_q, sym};
      op_o.triple_ok  = 1'b1;
      op_o.pair_ok    = 1'b1;
    end else begin
      op_valid_o      = accept_i;
      op_o.kind       = OP_QUERY;
      op_o.triple_idx = {query_first_i, query_second_i, query_third_i};
      op_o.pair_ok    = first_ok && second_ok;
      op_o.triple_ok  = first_ok && second_ok && third_ok;
    end
  end

  // History update on every accepted symbol.
  always_comb begin
    older_d = older_q;
    newer_d = newer_q;
    fill_d  = fill_q;
    if (accept_i && is_feed && sym_valid) begin
      older_d = newer_q;
      newer_d = sym;
      if (!history_full) begin
        fill_d = fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_q <= '0;
      newer_q <= '0;
      fill_q  <= '0;
    end else begin
      older_q <= older_d;
      newer_q <= newer_d;
      fill_q  <= fill_d;
    end
  end

endmodule

// ----- src/trifc_back.sv -----
// Back end: clears the counter memories, then runs count updates and queries.
`timescale 1ns / 1ps

module trifc_back import trifc_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                op_valid_i,
  input  trifc_op_t           op_i,
  output logic                op_pop_o,
  input  logic                pop_i,
  output logic                result_valid_o,
  output logic [OUT_W-1:0]    triple_count_o,
  output logic [OUT_W-1:0]    pair_count_o,
  output logic [OUT_W-1:0]    total_count_o,
  output trifc_status_t       status_o
);

  trifc_bk_state_e         state_q, state_d;
  logic [TRIPLE_IDX_W-1:0] clr_q, clr_d;
  trifc_op_t               cur_q, cur_d;
  logic [COUNT_WIDTH-1:0]  total_q, total_d;
  logic                    res_valid_q, res_valid_d;
  logic [OUT_W-1:0]        res_triple_q, res_pair_q, res_total_q;

  logic                    t_we, p_we;
  logic [TRIPLE_IDX_W-1:0] t_waddr;
  logic [PAIR_IDX_W-1:0]   p_waddr;
  logic [COUNT_WIDTH-1:0]  t_wdata, p_wdata;
  logic [COUNT_WIDTH-1:0]  t_rdata, p_rdata;
  logic [COUNT_WIDTH-1:0]  t_inc, p_inc, total_inc;
  logic                    op_pop;
  logic                    res_load;

  // Counter memories, read at the head of the queue.
  trifc_ram #(
    .WIDTH(COUNT_WIDTH),
    .DEPTH(TRIPLE_DEPTH)
  ) u_triple_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .raddr_i (op_i.triple_idx),
    .rdata_o (t_rdata)
  );

  trifc_ram #(
    .WIDTH(COUNT_WIDTH),
    .DEPTH(PAIR_DEPTH)
  ) u_pair_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (op_i.triple_idx[TRIPLE_IDX_W-1:SYM_W]),
    .rdata_o (p_rdata)
  );

  // Saturating increments.
  assign t_inc     = (t_rdata == '1) ? t_rdata : t_rdata + 1'b1;
  assign p_inc     = (p_rdata == '1) ? p_rdata : p_rdata + 1'b1;
  assign total_inc = (total_q == '1) ? total_q : total_q + 1'b1;

  // Sequencer: a clearing pass, then per operation a read as it is taken in BK_IDLE and an execute step in BK_EXEC.
  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    cur_d    = cur_q;
    total_d  = total_q;
    op_pop   = 1'b0;
    res_load = 1'b0;
    t_we     = 1'b0;
    p_we     = 1'b0;
    t_waddr  = cur_q.triple_idx;
    p_waddr  = cur_q.triple_idx[TRIPLE_IDX_W-1:SYM_W];
    t_wdata  = t_inc;
    p_wdata  = p_inc;
    case (state_q)
      BK_CLEAR: begin
        t_we    = 1'b1;
        p_we    = 1'b1;
        t_waddr = clr_q;
        p_waddr = clr_q[PAIR_IDX_W-1:0];
        t_wdata = '0;
        p_wdata = '0;
        clr_d   = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (op_valid_i && (op_i.kind == OP_COUNT || !res_valid_q || pop_i)) begin
          op_pop  = 1'b1;
          cur_d   = op_i;
          state_d = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (cur_q.kind == OP_COUNT) begin
          t_we    = 1'b1;
          p_we    = 1'b1;
          total_d = total_inc;
        end else begin
          res_load = 1'b1;
        end
        state_d = BK_IDLE;
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  // Result register occupancy.
  always_comb begin
    res_valid_d = res_valid_q;
    if (res_load) begin
      res_valid_d = 1'b1;
    end else if (pop_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_CLEAR;
      clr_q       <= '0;
      total_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      total_q     <= total_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Operation and result payload.
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (res_load) begin
      res_triple_q <= cur_q.triple_ok ? OUT_W'(t_rdata) : '0;
      res_pair_q   <= cur_q.pair_ok ? OUT_W'(p_rdata) : '0;
      res_total_q  <= OUT_W'(total_q);
    end
  end

  assign op_pop_o             = op_pop;
  assign result_valid_o       = res_valid_q;
  assign triple_count_o       = res_triple_q;
  assign pair_count_o         = res_pair_q;
  assign total_count_o        = res_total_q;
  assign status_o.clearing    = (state_q == BK_CLEAR);
  assign status_o.result_load = res_load;

endmodule

// ----- src/trigram_frequency_counter.sv -----
// Top level of the character trigram frequency counter.
//
//   Channel   Handshake         Payload
//   input     push_i / full_o   command_i, char_byte_i, query_first_i,
//                               query_second_i, query_third_i
//   result    pop_i / empty_o   triple_count_o, pair_count_o, total_count_o
//
// A counted symbol or a query passes through the back end in two steps: a read of
// the triple and pair counter memories, then a write of the increments or a load of
// the result register. Skipped bytes and history fills never reach the back end.
// After reset, a clearing pass zeroes the counter memories one entry per cycle
// across all 32768 triple entries; full_o stays high during that pass.
// The front end keeps accepting into a small queue while the back end is busy
// or a query result is waiting to be popped.
`timescale 1ns / 1ps

module trigram_frequency_counter import trifc_pkg::*; #(
  parameter int COUNT_WIDTH   = 32,
  parameter int ALPHABET_SIZE = 31,
  parameter int QUEUE_DEPTH   = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic        command_i,
  input  logic [7:0]  char_byte_i,
  input  logic [4:0]  query_first_i,
  input  logic [4:0]  query_second_i,
  input  logic [4:0]  query_third_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [31:0] triple_count_o,
  output logic [31:0] pair_count_o,
  output logic [31:0] total_count_o
);

  localparam int OP_W = $bits(trifc_op_t);

  logic          accept;
  logic          fe_valid;
  trifc_op_t     fe_op;
  logic          q_full;
  logic          q_valid;
  trifc_op_t     q_op;
  logic          q_pop;
  logic          res_valid;
  trifc_status_t status;

  assign full_o  = q_full || status.clearing;
  assign accept  = push_i && !full_o;
  assign empty_o = !res_valid;

  // Front end: classification and symbol history.
  trifc_front #(
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .command_i      (command_i),
    .char_byte_i    (char_byte_i),
    .query_first_i  (query_first_i),
    .query_second_i (query_second_i),
    .query_third_i  (query_third_i),
    .op_valid_o     (fe_valid),
    .op_o           (fe_op)
  );

  // Operation queue between the two halves.
  trifc_fifo #(
    .WIDTH(OP_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_valid),
    .data_i  (fe_op),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_op)
  );

  // Back end: counter memories and result register.
  trifc_back #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_valid_i     (q_valid),
    .op_i           (q_op),
    .op_pop_o       (q_pop),
    .pop_i          (pop_i),
    .result_valid_o (res_valid),
    .triple_count_o (triple_count_o),
    .pair_count_o   (pair_count_o),
    .total_count_o  (total_count_o),
    .status_o       (status)
  );

  // The back end never pulls from the queue during the clearing pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.clearing |-> !q_pop)
    else $error("queue popped during clearing pass");

  // A result is never loaded over one that is still waiting and not popped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.result_load |-> (empty_o || pop_i))
    else $error("result register overwritten");

  // A popped result with no new load leaves the result side empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && !empty_o && !status.result_load) |=> empty_o)
    else $error("result not retired after pop");

  // A loaded result shows up on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.result_load |=> !empty_o)
    else $error("loaded result not presented");

endmodule
